[rtl/core/sws_pkg.sv]
// Package for the stack with search and blockers.
// Holds field widths, operation and status codes, register map and the cell control type.
// No dependencies.
`default_nettype none

package sws_pkg;

    localparam int DepthDefault = 32;
    localparam int DataW        = 32;
    localparam int PosW         = 5;
    localparam int CapW         = 6;
    localparam int FuncW        = 2;
    localparam int StatusW      = 3;
    localparam int MaxResults   = 32;
    localparam int ApbAddrW     = 3;
    localparam int ApbDataW     = 32;

    localparam logic [CapW-1:0] CapReset = 6'd32;

    // Register index decoded from paddr[2].
    localparam logic RegCapacity = 1'b0;

    // Operation codes.
    localparam logic [FuncW-1:0] FnPush   = 2'd0;
    localparam logic [FuncW-1:0] FnPop    = 2'd1;
    localparam logic [FuncW-1:0] FnPeek   = 2'd2;
    localparam logic [FuncW-1:0] FnSearch = 2'd3;

    // Result status codes.
    localparam logic [StatusW-1:0] StPushed   = 3'd0;
    localparam logic [StatusW-1:0] StValue    = 3'd1;
    localparam logic [StatusW-1:0] StFull     = 3'd2;
    localparam logic [StatusW-1:0] StEmpty    = 3'd3;
    localparam logic [StatusW-1:0] StBlocker  = 3'd4;
    localparam logic [StatusW-1:0] StFound    = 3'd5;
    localparam logic [StatusW-1:0] StNotFound = 3'd6;

    // Control shared by every cell of the chain.
    typedef struct packed {
        logic push;  // take the value from the cell above (new value at the top)
        logic pop;   // take the value from the cell below
        logic rot;   // rotate the occupied part upward, top wraps to the bottom
    } sws_ctl_t;

endpackage : sws_pkg

`default_nettype wire

[rtl/core/stack_with_search_and_blockers.sv]
// Top level of the LIFO stack with search and blocker reporting.
// Depends on sws_pkg and instantiates a row of sws_cell storage cells.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tuser = func, s_tdata = value
//  m_        out        m_tvalid/m_tready  m_tuser = status, m_tdata = data, position; m_tlast
//  apb       in         psel/penable       capacity register at byte address 0
//
// Push, pop and peek: the request is taken in idle, its result is staged in the pending
// registers and then moves to the output register once that is free. A search rotates the
// entries through the top cell, one per cycle, once to find the lowest match; a miss then
// reports not found. A hit goes through a setup state and, unless the match is the top
// entry, a second pass that reports the blockers and restores the order.
// Reset clears the entry count and control state and sets capacity to 32; cell contents
// are not cleared. A stalled output holds the block; a new request is taken only in idle.
`default_nettype none

module stack_with_search_and_blockers #(
    parameter int DEPTH = sws_pkg::DepthDefault
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input requests.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [31:0] value
    input  logic [7:0]                   s_tuser,   // [1:0] func, [7:2] zero
    // Results.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,   // [31:0] data, [36:32] position, [39:37] zero
    output logic [7:0]                   m_tuser,   // [2:0] status, [7:3] zero
    output logic                         m_tlast,
    // Configuration.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sws_pkg::ApbAddrW-1:0] paddr,
    input  logic [sws_pkg::ApbDataW-1:0] pwdata,
    output logic [sws_pkg::ApbDataW-1:0] prdata,
    output logic                         pready
);
    import sws_pkg::*;

    // Count width holds 0 .. DEPTH; CmpW covers both count and capacity.
    localparam int CntW = $clog2(DEPTH + 1);
    localparam int CmpW = 7;

    // One-hot controller states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PREP = 5'b00100,
        S_WALK = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic [CapW-1:0]     cap_reg;
    logic [CntW-1:0]     step_reg, step_next;
    logic [CntW-1:0]     hit_reg, hit_next;
    logic                hit_valid_reg, hit_valid_next;
    logic [CntW-1:0]     nblk_reg, nblk_next;
    logic [DataW-1:0]    key_reg, key_next;

    // Pending final result of the current request.
    logic [StatusW-1:0]  pend_status_reg, pend_status_next;
    logic [DataW-1:0]    pend_data_reg, pend_data_next;
    logic [PosW-1:0]     pend_pos_reg, pend_pos_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [StatusW-1:0]  m_status_reg, m_status_next;
    logic [DataW-1:0]    m_data_reg, m_data_next;
    logic [PosW-1:0]     m_pos_reg, m_pos_next;
    logic                m_last_reg, m_last_next;

    sws_ctl_t            ctl;
    logic [DataW-1:0]    cell_q [DEPTH];
    logic                accept;
    logic                out_free;
    logic                cfg_write;
    logic [CmpW-1:0]     cap_eff;
    logic                is_full;
    logic [CntW-1:0]     slot;
    logic                step_done;
    logic [CntW-1:0]     diff;
    logic [FuncW-1:0]    func;

    // ------------------------------------------------------------------
    // Configuration port. Writes are expected between requests; the
    // capacity is only consulted by a push taken in idle.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegCapacity);
    assign prdata    = (paddr[2] == RegCapacity) ? ApbDataW'(cap_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CapReset;
        end else if (cfg_write) begin
            cap_reg <= pwdata[CapW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Chain of storage cells. Outside a rotation pass cell 0 holds the top of the
    // stack, so stack slot s lives in cell count-1-s.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DataW-1:0] up_d;
        logic [DataW-1:0] down_d;

        if (g == 0) begin : g_top
            assign up_d = s_tdata;
        end else begin : g_mid
            assign up_d = cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_bot
            assign down_d = cell_q[g];
        end else begin : g_upper
            assign down_d = cell_q[g+1];
        end

        sws_cell #(
            .CntW  (CntW),
            .Index (g)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .cnt       (cnt_reg),
            .up_data   (up_d),
            .down_data (down_d),
            .top_data  (cell_q[0]),
            .data      (cell_q[g])
        );
    end

    // ------------------------------------------------------------------
    // Controller.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign func     = s_tuser[FuncW-1:0];
    assign out_free = !m_valid_reg || m_tready;

    // Capacity above the depth is clipped to the depth.
    assign cap_eff  = (CmpW'(cap_reg) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(cap_reg);
    assign is_full  = (CmpW'(cnt_reg) >= cap_eff);

    // Slot currently sitting in the top cell during a rotation pass.
    assign slot      = cnt_reg - CntW'(1) - step_reg;
    assign step_done = (step_reg == cnt_reg - CntW'(1));
    assign diff      = cnt_reg - CntW'(1) - hit_reg;

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        step_next        = step_reg;
        hit_next         = hit_reg;
        hit_valid_next   = hit_valid_reg;
        nblk_next        = nblk_reg;
        key_next         = key_reg;
        pend_status_next = pend_status_reg;
        pend_data_next   = pend_data_reg;
        pend_pos_next    = pend_pos_reg;
        ctl              = '0;

        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_data_next      = m_data_reg;
        m_pos_next       = m_pos_reg;
        m_last_next      = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pend_data_next = '0;
                    pend_pos_next  = '0;
                    state_next     = S_EMIT;
                    case (func)
                        FnPush: begin
                            if (is_full) begin
                                pend_status_next = StFull;
                            end else begin
                                ctl.push         = 1'b1;
                                cnt_next         = cnt_reg + CntW'(1);
                                pend_status_next = StPushed;
                            end
                        end
                        FnPop, FnPeek: begin
                            if (cnt_reg == '0) begin
                                pend_status_next = StEmpty;
                            end else begin
                                pend_status_next = StValue;
                                pend_data_next   = cell_q[0];
                                if (func == FnPop) begin
                                    ctl.pop  = 1'b1;
                                    cnt_next = cnt_reg - CntW'(1);
                                end
                            end
                        end
                        FnSearch: begin
                            if (cnt_reg == '0) begin
                                pend_status_next = StNotFound;
                            end else begin
                                key_next       = s_tdata;
                                step_next      = '0;
                                hit_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        default: begin
                            pend_status_next = StNotFound;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Entries pass the top cell from the top slot down; the last match
                // seen is the lowest one.
                ctl.rot   = 1'b1;
                step_next = step_reg + CntW'(1);
                if (cell_q[0] == key_reg) begin
                    hit_next       = slot;
                    hit_valid_next = 1'b1;
                end
                if (step_done) begin
                    step_next = '0;
                    if (hit_valid_next) begin
                        state_next = S_PREP;
                    end else begin
                        pend_status_next = StNotFound;
                        pend_data_next   = '0;
                        pend_pos_next    = '0;
                        state_next       = S_EMIT;
                    end
                end
            end

            S_PREP: begin
                // Blockers above the match, at most one less than the result limit.
                if (CmpW'(diff) > CmpW'(MaxResults - 1)) begin
                    nblk_next = CntW'(MaxResults - 1);
                end else begin
                    nblk_next = diff;
                end
                pend_status_next = StFound;
                pend_data_next   = '0;
                pend_pos_next    = PosW'(hit_reg);
                step_next        = '0;
                if (diff == '0) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_WALK;
                end
            end

            S_WALK: begin
                // Report blockers while the output accepts them, then finish the
                // rotation so the stack is back in order.
                if (step_reg < nblk_reg) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = StBlocker;
                        m_data_next   = cell_q[0];
                        m_pos_next    = PosW'(slot);
                        m_last_next   = 1'b0;
                        ctl.rot       = 1'b1;
                        step_next     = step_reg + CntW'(1);
                        if (step_done) begin
                            state_next = S_EMIT;
                        end
                    end
                end else begin
                    ctl.rot   = 1'b1;
                    step_next = step_reg + CntW'(1);
                    if (step_done) begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pend_status_reg;
                    m_data_next   = pend_data_reg;
                    m_pos_next    = pend_pos_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            hit_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            hit_valid_reg <= hit_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        hit_reg         <= hit_next;
        nblk_reg        <= nblk_next;
        key_reg         <= key_next;
        pend_status_reg <= pend_status_next;
        pend_data_reg   <= pend_data_next;
        pend_pos_reg    <= pend_pos_next;
        m_status_reg    <= m_status_next;
        m_data_reg      <= m_data_next;
        m_pos_reg       <= m_pos_next;
        m_last_reg      <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_pos_reg, m_data_reg};
    assign m_tuser  = {5'b00000, m_status_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // The entry count never exceeds the number of cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        CmpW'(cnt_reg) <= CmpW'(DEPTH))
        else $error("entry count above depth");

    // Only an idle request changes the entry count; a search leaves it alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |=> $stable(cnt_reg))
        else $error("entry count changed outside idle");

    // Rotation passes never run past the occupied part of the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SCAN) || (state_reg == S_WALK)) |-> (step_reg < cnt_reg))
        else $error("rotation step beyond entry count");

    // Every result but a blocker closes its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_status_reg != StBlocker)))
        else $error("last flag does not match result status");
`endif

endmodule : stack_with_search_and_blockers

`default_nettype wire

[rtl/core/sws_cell.sv]
// One storage cell of the stack chain: holds one entry and shifts with its neighbors.
// Depends on sws_pkg for widths and the control struct.
`default_nettype none

module sws_cell #(
    parameter int CntW  = 6,
    parameter int Index = 0
) (
    input  logic                      aclk,
    input  sws_pkg::sws_ctl_t         ctl,
    input  logic [CntW-1:0]           cnt,
    input  logic [sws_pkg::DataW-1:0] up_data,
    input  logic [sws_pkg::DataW-1:0] down_data,
    input  logic [sws_pkg::DataW-1:0] top_data,
    output logic [sws_pkg::DataW-1:0] data
);
    import sws_pkg::*;

    logic [DataW-1:0] data_reg;
    logic [DataW-1:0] data_next;
    logic             is_bottom;

    // The lowest occupied cell receives the top entry during a rotation.
    assign is_bottom = (cnt == CntW'(Index + 1));

    always_comb begin
        data_next = data_reg;
        if (ctl.push) begin
            data_next = up_data;
        end else if (ctl.pop) begin
            data_next = down_data;
        end else if (ctl.rot) begin
            data_next = is_bottom ? top_data : down_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule : sws_cell

`default_nettype wire

[sim/tb_stack_with_search_and_blockers.sv]
// Self-checking testbench for stack_with_search_and_blockers: push, pop, peek and search
// requests go in on the s_ stream, and every result on the m_ stream is checked against a
// built-in stack predictor. Depends on sws_pkg and the RTL top level only.
module tb_stack_with_search_and_blockers;

    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    localparam int Depth      = DepthDefault;
    localparam int IdxW       = $clog2(Depth);
    localparam int HoldCycles = 200;

    // Register addresses on the APB port. Only byte address 0 is mapped; address 4
    // decodes to a register index that does not exist and must be ignored.
    localparam logic [ApbAddrW-1:0] AddrCapacity = 3'd0;
    localparam logic [ApbAddrW-1:0] AddrUnmapped = 3'd4;

    typedef struct packed {
        logic [FuncW-1:0] fn;
        logic [DataW-1:0] val;
    } stack_req_t;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [DataW-1:0]   data;
        logic [PosW-1:0]    pos;
        logic               last;
    } stack_result_t;

    // DUT ports. Every input has a known value from time zero.
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata  = '0;
    logic [7:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;
    logic [7:0]          m_tuser;
    logic                m_tlast;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ApbAddrW-1:0] paddr    = '0;
    logic [ApbDataW-1:0] pwdata   = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    // Requests waiting for the driver, and results still owed by the block in order.
    stack_req_t    pending_reqs [$];
    stack_result_t owed_results [$];

    // Predictor state: a private copy of the stack and of the capacity register.
    logic [DataW-1:0] model_mem [Depth];
    int unsigned      model_count = 0;
    logic [CapW-1:0]  model_cap   = CapReset;

    // Idling control. idle_enable turns the random bursts on both sides on or off;
    // sink_hold is the long receiver stall used to back the block up.
    logic idle_enable = 1'b1;
    logic hold_go     = 1'b0;
    logic sink_hold   = 1'b0;
    int   src_gap     = 0;
    int   sink_gap    = 0;

    // Bookkeeping for the verdict and the closing summary.
    int mismatches = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_blockers = 0;
    int n_found    = 0;
    int n_notfound = 0;
    int n_full     = 0;
    int n_empty    = 0;

    stack_with_search_and_blockers #(.DEPTH(Depth)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [31:0] value
        .s_tuser (s_tuser),   // [1:0] func, [7:2] zero
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [31:0] data, [36:32] position, [39:37] zero
        .m_tuser (m_tuser),   // [2:0] status, [7:3] zero
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs. The slowest legal run is far below this.
    initial begin
        #5_000_000;
        $display("%0t timeout: %0d results still owed", $time, owed_results.size());
        $display("tb_stack_with_search_and_blockers NOT OK");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch in %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic owe_result(input logic [StatusW-1:0] status, input logic [DataW-1:0] data,
                              input logic [PosW-1:0] pos, input logic last);
        owed_results.push_back('{status: status, data: data, pos: pos, last: last});
    endtask

    // Stack predictor. Applies one accepted request to the private stack copy and
    // queues every result that the block owes for it, in the order it must send them.
    task automatic model_stack_op(input logic [FuncW-1:0] fn, input logic [DataW-1:0] val);
        int unsigned cap;
        int unsigned hit;
        int unsigned lowest;
        int unsigned i;
        cap = (32'(model_cap) > 32'(Depth)) ? 32'(Depth) : 32'(model_cap);
        n_accepted++;
        case (fn)
            FnPush: begin
                if (model_count >= cap) begin
                    // Covers capacity zero and capacity lowered under the count too.
                    owe_result(StFull, '0, '0, 1'b1);
                    n_full++;
                end else begin
                    model_mem[IdxW'(model_count)] = val;
                    model_count++;
                    owe_result(StPushed, '0, '0, 1'b1);
                end
            end
            FnPop, FnPeek: begin
                if (model_count == 0) begin
                    owe_result(StEmpty, '0, '0, 1'b1);
                    n_empty++;
                end else begin
                    owe_result(StValue, model_mem[IdxW'(model_count - 1)], '0, 1'b1);
                    if (fn == FnPop) begin
                        model_count--;
                    end
                end
            end
            default: begin
                // Lowest matching slot wins; a duplicate higher up is just a blocker.
                hit = model_count;
                for (i = 0; i < model_count; i++) begin
                    if (hit == model_count && model_mem[IdxW'(i)] == val) begin
                        hit = i;
                    end
                end
                if (hit == model_count) begin
                    owe_result(StNotFound, '0, '0, 1'b1);
                    n_notfound++;
                end else begin
                    lowest = hit + 1;
                    if (model_count - hit > MaxResults) begin
                        lowest = model_count - (MaxResults - 1);
                    end
                    for (i = model_count; i > lowest; i--) begin
                        owe_result(StBlocker, model_mem[IdxW'(i - 1)], PosW'(i - 1), 1'b0);
                        n_blockers++;
                    end
                    owe_result(StFound, '0, PosW'(hit), 1'b1);
                    n_found++;
                end
            end
        endcase
    endtask

    // Request driver. A request is taken when s_tvalid and s_tready are both high at
    // an edge; the predictor is updated right there so expectations keep their order.
    // Between requests it may idle for a random burst of cycles.
    always @(posedge aclk) begin : drive_requests
        logic       offering;
        stack_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap  = 0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                model_stack_op(s_tuser[FuncW-1:0], s_tdata);
                offering = 1'b0;
            end
            if (!offering) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_reqs.size() != 0) begin
                    req = pending_reqs.pop_front();
                    s_tdata  <= req.val;
                    s_tuser  <= {{(8-FuncW){1'b0}}, req.fn};
                    offering = 1'b1;
                    if (idle_enable && $urandom_range(0, 3) == 0) begin
                        src_gap = $urandom_range(1, 16);
                    end
                end
            end
            // Single assignment per edge so a back-to-back valid is never glitched.
            s_tvalid <= offering;
        end
    end

    // Result monitor and receiver. Each result taken is compared field by field with
    // the oldest owed result; the ready line idles in random bursts or for the long hold.
    always @(posedge aclk) begin : check_results
        stack_result_t want;
        logic          rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (owed_results.size() == 0) begin
                    flag_mismatch("unexpected result, status",
                                  32'(m_tuser[StatusW-1:0]), '0);
                end else begin
                    want = owed_results.pop_front();
                    if (m_tuser[StatusW-1:0] !== want.status) begin
                        flag_mismatch("status", 32'(m_tuser[StatusW-1:0]),
                                      32'(want.status));
                    end
                    if (m_tdata[DataW-1:0] !== want.data) begin
                        flag_mismatch("data", m_tdata[DataW-1:0], want.data);
                    end
                    if (m_tdata[DataW+PosW-1:DataW] !== want.pos) begin
                        flag_mismatch("position", 32'(m_tdata[DataW+PosW-1:DataW]),
                                      32'(want.pos));
                    end
                    if (m_tlast !== want.last) begin
                        flag_mismatch("last", 32'(m_tlast), 32'(want.last));
                    end
                end
            end
            if (sink_hold) begin
                rdy = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (idle_enable && $urandom_range(0, 4) == 0) begin
                    sink_gap = $urandom_range(1, 16);
                end
            end
            m_tready <= rdy;
        end
    end

    // Long receiver stall, counted here so the sender keeps offering requests while
    // the block's result register stays full and s_tready has to drop.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HoldCycles) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // APB write: setup cycle, then access cycle. The register takes the value at the
    // edge that closes the access cycle, which is when the predictor copy is updated.
    // Upper data bits are random since only the low six bits belong to the register.
    task automatic write_capacity_reg(input logic [ApbAddrW-1:0] addr,
                                      input logic [CapW-1:0] cap_val);
        logic [ApbDataW-1:0] wdata;
        wdata = $urandom();
        wdata[CapW-1:0] = cap_val;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr[2] == RegCapacity) begin
            model_cap = cap_val;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_req(input logic [FuncW-1:0] fn, input logic [DataW-1:0] val);
        pending_reqs.push_back('{fn: fn, val: val});
    endtask

    // Random traffic. Values come mostly from a small pool so that searches hit often
    // and produce blockers; the rest are fully random words. The push and pop shares
    // steer the fill level toward full or toward empty.
    task automatic queue_random_reqs(input int n, input int push_pct, input int pop_pct);
        logic [DataW-1:0] pool [6];
        logic [DataW-1:0] corner [4];
        int               roll;
        int               k;
        stack_req_t       req;
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        foreach (pool[j]) begin
            pool[j] = $urandom();
        end
        pool[3'($urandom_range(0, 5))] = corner[2'($urandom_range(0, 3))];
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                req.fn = FnPush;
            end else if (roll < push_pct + pop_pct) begin
                req.fn = ($urandom_range(0, 2) == 0) ? FnPeek : FnPop;
            end else begin
                req.fn = FnSearch;
            end
            req.val = ($urandom_range(0, 6) == 0) ? DataW'($urandom())
                                                  : pool[3'($urandom_range(0, 5))];
            pending_reqs.push_back(req);
        end
    endtask

    // Waits until every queued request has been taken and every owed result has come.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_reqs.size() != 0 || s_tvalid || owed_results.size() != 0);
    endtask

    initial begin : stimulus
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset capacity: empty-stack requests first, then the
        // field extremes, a duplicate entry, and searches that hit the bottom, a middle
        // slot with blockers above it, and nothing at all.
        queue_req(FnPop, 32'h0000_0000);
        queue_req(FnPeek, 32'hFFFF_FFFF);
        queue_req(FnSearch, 32'h0000_0005);
        queue_req(FnPush, 32'h7FFF_FFFF);
        queue_req(FnPush, 32'h8000_0000);
        queue_req(FnPush, 32'h0000_0000);
        queue_req(FnPush, 32'hFFFF_FFFF);
        queue_req(FnPush, 32'h8000_0000);
        queue_req(FnPeek, 32'h0000_0000);
        queue_req(FnSearch, 32'h8000_0000);
        queue_req(FnSearch, 32'h7FFF_FFFF);
        queue_req(FnSearch, 32'hFFFF_FFFF);
        queue_req(FnSearch, 32'h0000_0001);
        queue_req(FnPop, 32'h0000_0000);
        wait_drained();

        // Capacity lowered below the current count: pushes are refused until pops
        // bring the count under it, while search and pop keep working.
        write_capacity_reg(AddrCapacity, 6'd2);
        queue_req(FnPush, 32'h0000_0001);
        queue_req(FnSearch, 32'h0000_0000);
        queue_req(FnPop, 32'h0000_0000);
        queue_req(FnPop, 32'h0000_0000);
        queue_req(FnPush, 32'h0000_0002);
        queue_req(FnPop, 32'h0000_0000);
        queue_req(FnPush, 32'h5555_5555);
        wait_drained();

        // Capacity zero refuses every push; a write to an unmapped address changes nothing.
        write_capacity_reg(AddrCapacity, 6'd0);
        queue_req(FnPush, 32'hAAAA_AAAA);
        queue_req(FnPeek, 32'h0000_0000);
        wait_drained();
        write_capacity_reg(AddrUnmapped, 6'd1);
        queue_req(FnPush, 32'h1234_5678);
        wait_drained();

        // Capacity above the depth is clipped to the depth. Fill the stack to the brim
        // while the receiver is held off, so the block backs up and stalls its input,
        // then search for the bottom entry to get the longest blocker list.
        write_capacity_reg(AddrCapacity, 6'd63);
        hold_go = 1'b1;
        for (k = 0; k < Depth - 1; k++) begin
            queue_req(FnPush, $urandom());
        end
        queue_req(FnPeek, 32'h0000_0000);
        queue_req(FnSearch, 32'h7FFF_FFFF);
        wait_drained();

        // Random part, several capacity settings. The first phase drains the full
        // stack down through empty; later ones fill and churn at different sizes.
        queue_random_reqs(80, 10, 80);
        wait_drained();
        write_capacity_reg(AddrCapacity, 6'd1);
        queue_random_reqs(40, 45, 30);
        wait_drained();
        write_capacity_reg(AddrCapacity, CapW'($urandom_range(3, 31)));
        queue_random_reqs(50, 45, 30);
        wait_drained();
        write_capacity_reg(AddrCapacity, 6'd32);
        queue_random_reqs(60, 50, 20);
        wait_drained();

        // Last stretch runs at full rate on both sides.
        idle_enable <= 1'b0;
        write_capacity_reg(AddrCapacity, CapW'($urandom_range(1, 32)));
        queue_random_reqs(70, 40, 35);
        wait_drained();

        // Let a possible trailing search pass finish; a stray result would be caught.
        repeat (2 * Depth + 8) @(posedge aclk);

        $display("Ran %0d stack requests and checked %0d results:", n_accepted, n_checked);
        $display("%0d refused pushes, %0d empty reads.", n_full, n_empty);
        $display("Searches: %0d hits reporting %0d blocking entries, %0d misses.",
                 n_found, n_blockers, n_notfound);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("tb_stack_with_search_and_blockers OK");
        end else begin
            $display("tb_stack_with_search_and_blockers NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/sws_pkg.sv
rtl/core/sws_cell.sv
rtl/core/stack_with_search_and_blockers.sv
sim/tb_stack_with_search_and_blockers.sv
